// ===== hdl/k_grp_pkg.sv =====
// ---------------------------------------------------------------------------
// k_grp_pkg
// Shared types and constants for the group reversal block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package k_grp_pkg;

    localparam int VALUE_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 5'd4;

    // control part of one queued group request
    typedef struct packed {
        logic bank;
        logic reversed;
        logic stream_end;
    } t_grp_ctl;

endpackage

`default_nettype wire

// ===== hdl/k_grp_front.sv =====
// ---------------------------------------------------------------------------
// k_grp_front
// Accepts values, writes them into the current buffer bank and, when a group
// fills or the stream ends, queues a group request and swaps banks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module k_grp_front #(
    parameter int MAX_GROUP = 16,
    parameter int IDX_W     = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [k_grp_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [k_grp_pkg::VALUE_W-1:0] i_value,
    input  wire logic                          i_stream_end,
    output logic                               o_wr_en,
    output logic [IDX_W:0]                     o_wr_addr,
    output logic [k_grp_pkg::VALUE_W-1:0]      o_wr_data,
    output logic                               o_push,
    output k_grp_pkg::t_grp_ctl                o_push_ctl,
    output logic [IDX_W-1:0]                   o_push_last_idx,
    input  wire logic                          i_push_ready,
    input  wire logic                          i_release,
    input  wire logic                          i_release_bank
);

    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > k_grp_pkg::CFG_W) ? CNT_W : k_grp_pkg::CFG_W;

    logic [k_grp_pkg::CFG_W-1:0] r_group_size;
    logic [IDX_W-1:0]            r_fill;
    logic                        r_bank;
    logic [1:0]                  r_busy;
    logic [1:0]                  n_busy;

    logic             accept;
    logic [CMP_W-1:0] k_eff;
    logic [CMP_W-1:0] cnt_after;
    logic             full;
    logic             flush;

    always_comb begin
        if (r_group_size == '0) begin
            k_eff = CMP_W'(1);
        end else if (CMP_W'(r_group_size) > CMP_W'(MAX_GROUP)) begin
            k_eff = CMP_W'(MAX_GROUP);
        end else begin
            k_eff = CMP_W'(r_group_size);
        end
    end

    assign cnt_after = CMP_W'(r_fill) + CMP_W'(1);
    assign full      = cnt_after >= k_eff;
    assign flush     = full || i_stream_end;

    assign o_ready = !r_busy[r_bank] && i_push_ready;
    assign accept  = i_valid && o_ready;

    assign o_wr_en   = accept;
    assign o_wr_addr = {r_bank, r_fill};
    assign o_wr_data = i_value;

    assign o_push                = accept && flush;
    assign o_push_ctl.bank       = r_bank;
    assign o_push_ctl.reversed   = full;
    assign o_push_ctl.stream_end = i_stream_end;
    assign o_push_last_idx       = r_fill;

    always_comb begin
        n_busy = r_busy;
        if (i_release) begin
            n_busy[i_release_bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= k_grp_pkg::GROUP_SIZE_RESET;
            r_fill       <= '0;
            r_bank       <= 1'b0;
            r_busy       <= '0;
        end else begin
            r_busy <= n_busy;
            if (i_cfg_valid) begin
                r_group_size <= i_cfg_data;
            end
            if (accept) begin
                if (flush) begin
                    r_fill <= '0;
                    r_bank <= ~r_bank;
                end else begin
                    r_fill <= r_fill + IDX_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/k_grp_queue.sv =====
// ---------------------------------------------------------------------------
// k_grp_queue
// Two-entry queue of group requests between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module k_grp_queue #(
    parameter int IDX_W = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire k_grp_pkg::t_grp_ctl  i_ctl,
    input  wire logic [IDX_W-1:0]     i_last_idx,
    output logic                      o_ready,
    input  wire logic                 i_pop,
    output logic                      o_valid,
    output k_grp_pkg::t_grp_ctl       o_ctl,
    output logic [IDX_W-1:0]          o_last_idx
);

    k_grp_pkg::t_grp_ctl r_ctl [2];
    logic [IDX_W-1:0]    r_idx [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;

    logic do_push;
    logic do_pop;

    assign o_ready    = r_count != 2'd2;
    assign o_valid    = r_count != 2'd0;
    assign o_ctl      = r_ctl[r_rd_ptr];
    assign o_last_idx = r_idx[r_rd_ptr];

    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ctl[r_wr_ptr] <= i_ctl;
            r_idx[r_wr_ptr] <= i_last_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/k_grp_back.sv =====
// ---------------------------------------------------------------------------
// k_grp_back
// Holds the two-bank value buffer and plays out queued groups, forward or
// reversed, through a registered read into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module k_grp_back #(
    parameter int IDX_W = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [IDX_W:0]                i_wr_addr,
    input  wire logic [k_grp_pkg::VALUE_W-1:0] i_wr_data,
    input  wire logic                          i_q_valid,
    input  wire k_grp_pkg::t_grp_ctl           i_q_ctl,
    input  wire logic [IDX_W-1:0]              i_q_last_idx,
    output logic                               o_q_pop,
    output logic                               o_release,
    output logic                               o_release_bank,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [k_grp_pkg::VALUE_W-1:0]      o_value,
    output logic                               o_run_last,
    output logic                               o_stream_end
);

    localparam int DEPTH = 2 << IDX_W;

    logic [k_grp_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [k_grp_pkg::VALUE_W-1:0] r_rd_data;

    logic                r_active;
    k_grp_pkg::t_grp_ctl r_ctl;
    logic [IDX_W-1:0]    r_last_idx;
    logic [IDX_W-1:0]    r_pos;
    logic                r_out_valid;
    logic                r_out_last;
    logic                r_out_end;

    logic             issue;
    logic             last;
    logic [IDX_W-1:0] rd_idx;

    assign issue  = r_active && (!r_out_valid || i_ready);
    assign last   = r_pos == r_last_idx;
    assign rd_idx = r_ctl.reversed ? (r_last_idx - r_pos) : r_pos;

    assign o_q_pop        = i_q_valid && (!r_active || (issue && last));
    assign o_release      = issue && last;
    assign o_release_bank = r_ctl.bank;

    assign o_valid      = r_out_valid;
    assign o_value      = r_rd_data;
    assign o_run_last   = r_out_last;
    assign o_stream_end = r_out_end;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{r_ctl.bank, rd_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ctl      <= i_q_ctl;
            r_last_idx <= i_q_last_idx;
        end
        if (issue) begin
            r_out_last <= last;
            r_out_end  <= last && r_ctl.stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_active <= 1'b1;
                r_pos    <= '0;
            end else if (issue) begin
                if (last) begin
                    r_active <= 1'b0;
                end
                r_pos <= r_pos + IDX_W'(1);
            end
            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/k_group_reverse.sv =====
// ---------------------------------------------------------------------------
// k_group_reverse
// Reorders a stream of signed values in groups of a configured size; a
// partial group at the end of a stream passes in its original order.
// ---------------------------------------------------------------------------
//  channel   direction  payload (low bit up)
//  s_axis    in         tdata: value; tlast: stream_end
//  m_axis    out        tdata: out_value; tlast: run_last; tuser: out_stream_end
//  cfg       in         i_cfg_data: group_size
//
//  Values enter at up to one per cycle; a group is played out at one per cycle
//  while the output is not stalled, after a turnaround through the request
//  queue and buffer read. Two buffer banks bound throughput: whatever the
//  group size, the input stalls in about every second group. Synchronous
//  active-low reset; no clearing pass. The output register lets input and
//  output stall independently.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module k_group_reverse #(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [k_grp_pkg::CFG_W-1:0]        i_cfg_data,   // group_size
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic signed [k_grp_pkg::VALUE_W-1:0] s_axis_tdata, // value
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic signed [k_grp_pkg::VALUE_W-1:0]    m_axis_tdata, // out_value
    output logic                                    m_axis_tlast,
    output logic [0:0]                              m_axis_tuser  // out_stream_end
);

    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic                          wr_en;
    logic [IDX_W:0]                wr_addr;
    logic [k_grp_pkg::VALUE_W-1:0] wr_data;
    logic                          push;
    k_grp_pkg::t_grp_ctl           push_ctl;
    logic [IDX_W-1:0]              push_last_idx;
    logic                          push_ready;
    logic                          pop;
    logic                          q_valid;
    k_grp_pkg::t_grp_ctl           q_ctl;
    logic [IDX_W-1:0]              q_last_idx;
    logic                          release_grp;
    logic                          release_bank;
    logic [k_grp_pkg::VALUE_W-1:0] out_value;
    logic                          out_end;

    assign o_cfg_ready     = 1'b1;
    assign m_axis_tdata    = out_value;
    assign m_axis_tuser[0] = out_end;

    k_grp_front #(
        .MAX_GROUP (MAX_GROUP),
        .IDX_W     (IDX_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_value         (s_axis_tdata),
        .i_stream_end    (s_axis_tlast),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_push          (push),
        .o_push_ctl      (push_ctl),
        .o_push_last_idx (push_last_idx),
        .i_push_ready    (push_ready),
        .i_release       (release_grp),
        .i_release_bank  (release_bank)
    );

    k_grp_queue #(
        .IDX_W (IDX_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_ctl      (push_ctl),
        .i_last_idx (push_last_idx),
        .o_ready    (push_ready),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_ctl      (q_ctl),
        .o_last_idx (q_last_idx)
    );

    k_grp_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_data      (wr_data),
        .i_q_valid      (q_valid),
        .i_q_ctl        (q_ctl),
        .i_q_last_idx   (q_last_idx),
        .o_q_pop        (pop),
        .o_release      (release_grp),
        .o_release_bank (release_bank),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_value        (out_value),
        .o_run_last     (m_axis_tlast),
        .o_stream_end   (out_end)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for k_group_reverse. A short table of directed requests
// and register writes runs first, then random streams under several group
// sizes and handshake idling patterns, and a long output hold-off that fills
// the block. Outputs are checked by a group reversal predictor or typed rows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_GROUP = 16;

    typedef struct packed {
        logic [k_grp_pkg::VALUE_W-1:0] value;
        logic                          run_last;
        logic                          stream_end;
    } t_out_elem;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // typed: output is the input value alone, run_last set, stream_end = fin
    typedef struct packed {
        t_row_kind                     kind;
        logic [k_grp_pkg::VALUE_W-1:0] data;
        logic                          fin;
        logic                          typed;
    } t_row;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [k_grp_pkg::CFG_W-1:0]          i_cfg_data = '0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic signed [k_grp_pkg::VALUE_W-1:0] s_axis_tdata = '0;    // value
    logic                                 s_axis_tlast = 1'b0;  // stream_end
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic signed [k_grp_pkg::VALUE_W-1:0] m_axis_tdata;         // out_value
    logic                                 m_axis_tlast;         // run_last
    logic [0:0]                           m_axis_tuser;         // out_stream_end

    k_group_reverse #(.MAX_GROUP(MAX_GROUP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    t_out_elem                     pending_out[$];
    logic [k_grp_pkg::VALUE_W-1:0] held_vals[MAX_GROUP];
    int unsigned                   held_cnt = 0;
    logic [k_grp_pkg::CFG_W-1:0]   grp_size_reg = k_grp_pkg::GROUP_SIZE_RESET;
    int                            errors = 0;
    int                            tx_idle_pct = 0;
    int                            rx_idle_pct = 0;
    int                            rx_hold_len = 0;
    int                            rx_hold_left = 0;

    t_row script[25] = '{
        '{ROW_ITEM, 32'h0000_0001, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h0000_0002, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h0000_0003, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h0000_0004, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h0000_0005, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h0000_0006, 1'b1, 1'b0},
        '{ROW_CFG,  32'd1,         1'b0, 1'b0},
        '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b1},
        '{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b1},
        '{ROW_CFG,  32'd0,         1'b0, 1'b0},
        '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 1'b1},
        '{ROW_ITEM, 32'h0000_0000, 1'b1, 1'b1},
        '{ROW_CFG,  32'd3,         1'b0, 1'b0},
        '{ROW_ITEM, 32'h1234_5678, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h9ABC_DEF0, 1'b0, 1'b0},
        '{ROW_CFG,  32'd2,         1'b0, 1'b0},
        '{ROW_ITEM, 32'h0F0F_0F0F, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h1111_1111, 1'b0, 1'b0},
        '{ROW_ITEM, 32'hEEEE_EEEE, 1'b1, 1'b0},
        '{ROW_CFG,  32'd31,        1'b0, 1'b0},
        '{ROW_ITEM, 32'hA5A5_A5A5, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h5A5A_5A5A, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h0000_0001, 1'b0, 1'b0},
        '{ROW_ITEM, 32'hFFFF_FFFE, 1'b0, 1'b0},
        '{ROW_ITEM, 32'h8000_0001, 1'b1, 1'b0}
    };

    // buffer one value; on a full group or a stream end, queue the group
    function automatic void reorder_predict(input logic [k_grp_pkg::VALUE_W-1:0] v,
                                            input logic fin,
                                            input bit publish);
        int unsigned k;
        int unsigned n;
        int unsigned src;
        bit          rev;
        t_out_elem   e;
        k = grp_size_reg;
        if (k == 0) k = 1;
        if (k > MAX_GROUP) k = MAX_GROUP;
        if (held_cnt >= MAX_GROUP) held_cnt = MAX_GROUP - 1;
        held_vals[held_cnt] = v;
        held_cnt++;
        if (held_cnt >= k) rev = 1'b1;
        else if (fin) rev = 1'b0;
        else return;
        n = held_cnt;
        for (int unsigned i = 0; i < n; i++) begin
            src          = rev ? (n - 1 - i) : i;
            e.value      = held_vals[src];
            e.run_last   = (i + 1 == n);
            e.stream_end = (i + 1 == n) && fin;
            if (publish) pending_out.push_back(e);
        end
        held_cnt = 0;
    endfunction

    always @(negedge i_clk) begin
        if (rx_hold_len != 0) begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_elem want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %h last=%b end=%b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                errors++;
            end else begin
                want = pending_out.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tlast !== want.run_last ||
                    m_axis_tuser[0] !== want.stream_end) begin
                    $display("%0t: mismatch: expected %h last=%b end=%b, got %h last=%b end=%b",
                             $time, want.value, want.run_last, want.stream_end,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic push_value(input logic [k_grp_pkg::VALUE_W-1:0] v, input logic fin,
                              input bit typed);
        t_out_elem e;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        reorder_predict(v, fin, !typed);
        if (typed) begin
            e = '{value: v, run_last: 1'b1, stream_end: fin};
            pending_out.push_back(e);
        end
        @(negedge i_clk);
    endtask

    // hold the input until every queued result is out, then let the block settle
    task automatic drain_out();
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_group_size(input logic [k_grp_pkg::CFG_W-1:0] sz);
        drain_out();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sz;
        do @(posedge i_clk); while (!o_cfg_ready);
        grp_size_reg = sz;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [k_grp_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [k_grp_pkg::CFG_W-1:0] sizes[9];
        int                          n_items;
        sizes = '{5'd1, 5'd16, 5'd31, 5'd2, 5'd0, 5'd7, 5'd3, 5'd5, 5'd16};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 32;
        rx_idle_pct = 85;
        foreach (script[r]) begin
            if (script[r].kind == ROW_CFG)
                write_group_size(script[r].data[k_grp_pkg::CFG_W-1:0]);
            else
                push_value(script[r].data, script[r].fin, script[r].typed);
        end

        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin
                    tx_idle_pct = 32;
                    rx_idle_pct = 85;
                end
                1: begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 32;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_group_size(ph == 6 ? 5'($urandom_range(31)) : sizes[ph]);
            n_items = (grp_size_reg > 8) ? 8 : 6;
            for (int i = 0; i < n_items; i++)
                push_value(pick_value(), $urandom_range(9) == 0, 1'b0);
        end

        // long output hold-off with the input kept busy, so the block backs up
        write_group_size(5'd16);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        rx_hold_len = 300;
        @(negedge i_clk);
        for (int i = 0; i < 36; i++)
            push_value(pick_value(), i == 35, 1'b0);

        drain_out();
        repeat (20) @(posedge i_clk);
        if (pending_out.size() != 0) errors++;
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== k_group_reverse.f =====
hdl/k_grp_pkg.sv
hdl/k_grp_front.sv
hdl/k_grp_queue.sv
hdl/k_grp_back.sv
hdl/k_group_reverse.sv
test/testbench.sv
